@@ hw/rtl/jls_pkg.sv @@
// ----------------------------------------------------------------------------
// jls_pkg: shared types for the joystick locomotion sequencer
// Phase and register codes, controller states, and the command, status,
// configuration and result records passed between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package jls_pkg;

  // Reset values of the configuration registers.
  localparam logic [14:0] DEADZONE_RST     = 15'd4915;
  localparam logic [15:0] FORWARD_GAIN_RST = 16'd3855;
  localparam logic [15:0] LATERAL_GAIN_RST = 16'd2409;
  localparam logic [15:0] TURN_GAIN_RST    = 16'd3855;
  localparam logic [15:0] SPRINT_GAIN_RST  = 16'd8192;
  localparam logic [15:0] STANDUP_WAIT_RST = 16'd3000;
  localparam logic [14:0] MOTION_THR_RST   = 15'd41;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    REG_DEADZONE     = 3'd0,
    REG_FORWARD_GAIN = 3'd1,
    REG_LATERAL_GAIN = 3'd2,
    REG_TURN_GAIN    = 3'd3,
    REG_SPRINT_GAIN  = 3'd4,
    REG_STANDUP_WAIT = 3'd5,
    REG_MOTION_THR   = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_STANDING = 3'd1,
    PH_AWAIT    = 3'd2,
    PH_ACTIVE   = 3'd3,
    PH_STOPPED  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    SPD_NONE   = 2'd0,
    SPD_NORMAL = 2'd1,
    SPD_HIGH   = 2'd2
  } speed_cmd_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_LAT,
    CS_TURN,
    CS_FWD,
    CS_SPR,
    CS_FIN,
    CS_EMIT
  } ctl_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_LAT,
    OP_MUL_TURN,
    OP_MUL_FWD,
    OP_MUL_SPR,
    OP_COMMIT
  } dp_op_t;

  typedef struct packed {
    logic [14:0] deadzone;
    logic [15:0] forward_gain;
    logic [15:0] lateral_gain;
    logic [15:0] turn_gain;
    logic [15:0] sprint_gain;
    logic [15:0] standup_wait_ms;
    logic [14:0] motion_threshold;
  } cfg_t;

  typedef struct packed {
    dp_op_t op;
    logic   sprint;
  } dp_cmd_t;

  typedef struct packed {
    logic moved;
  } dp_sts_t;

  typedef struct packed {
    logic       emit;
    phase_t     phase;
    logic       vel_valid;
    logic       stand;
    logic       start;
    speed_cmd_t speed;
    logic       stop;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/jls_dp.sv @@
// ----------------------------------------------------------------------------
// jls_dp: axis shaping datapath
// Deadzone subtraction, one shared 16x16 multiplier stepped over the axes,
// optional sprint scaling, saturation and the held velocity registers.
// ----------------------------------------------------------------------------
`default_nettype none

module jls_dp import jls_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic signed [15:0] in_lat,
  input  wire logic signed [15:0] in_fwd,
  input  wire logic signed [15:0] in_turn,
  input  wire dp_cmd_t            cmd,
  output dp_sts_t                 sts,
  output logic signed [15:0]      fwd_hold,
  output logic signed [15:0]      lat_hold,
  output logic signed [15:0]      turn_hold
);

  // Magnitude above the deadzone, zero inside it.
  function automatic logic [15:0] axis_diff(logic signed [15:0] v, logic [14:0] dz);
    logic [15:0] mag;
    mag = v[15] ? (~v + 16'd1) : v;
    return (mag >= {1'b0, dz}) ? (mag - {1'b0, dz}) : 16'd0;
  endfunction

  function automatic logic signed [15:0] sat_vel(logic [19:0] m, logic neg);
    if (neg) begin
      return (m > 20'd32768) ? 16'sh8000 : $signed(~m[15:0] + 16'd1);
    end
    return (m > 20'd32767) ? 16'sh7FFF : $signed(m[15:0]);
  endfunction

  function automatic logic [15:0] sat_mag(logic [19:0] m, logic neg);
    if (neg) begin
      return (m > 20'd32768) ? 16'd32768 : m[15:0];
    end
    return (m > 20'd32767) ? 16'd32767 : m[15:0];
  endfunction

  logic [15:0] diff_lat_r, diff_fwd_r, diff_turn_r;
  logic        neg_lat_r, neg_fwd_r, neg_turn_r;
  logic [31:0] prod_r, prod_nxt;
  logic [15:0] lat_m_r, turn_m_r;
  logic signed [15:0] fwd_hold_r, lat_hold_r, turn_hold_r;
  logic signed [15:0] fwd_sat, lat_sat, turn_sat;
  logic [15:0] mul_a, mul_b;
  logic [19:0] fwd_m;

  always_comb begin
    unique case (cmd.op)
      OP_MUL_LAT: begin
        mul_a = diff_lat_r;
        mul_b = cfg.lateral_gain;
      end
      OP_MUL_TURN: begin
        mul_a = diff_turn_r;
        mul_b = cfg.turn_gain;
      end
      OP_MUL_FWD: begin
        mul_a = diff_fwd_r;
        mul_b = cfg.forward_gain;
      end
      OP_MUL_SPR: begin
        mul_a = prod_r[30:15];
        mul_b = cfg.sprint_gain;
      end
      default: begin
        mul_a = 16'd0;
        mul_b = 16'd0;
      end
    endcase
    prod_nxt = 32'(mul_a) * 32'(mul_b);
  end

  // The forward product sits in prod_r at the final step, scaled once or twice.
  assign fwd_m    = cmd.sprint ? prod_r[31:12] : {4'd0, prod_r[30:15]};
  assign fwd_sat  = sat_vel(fwd_m, neg_fwd_r);
  assign lat_sat  = sat_vel({4'd0, lat_m_r}, neg_lat_r);
  assign turn_sat = sat_vel({4'd0, turn_m_r}, neg_turn_r);

  assign sts.moved = (sat_mag(fwd_m, neg_fwd_r) > {1'b0, cfg.motion_threshold}) ||
                     (sat_mag({4'd0, lat_m_r}, neg_lat_r) > {1'b0, cfg.motion_threshold}) ||
                     (sat_mag({4'd0, turn_m_r}, neg_turn_r) > {1'b0, cfg.motion_threshold});

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        diff_lat_r  <= axis_diff(in_lat, cfg.deadzone);
        diff_fwd_r  <= axis_diff(in_fwd, cfg.deadzone);
        diff_turn_r <= axis_diff(in_turn, cfg.deadzone);
        neg_lat_r   <= in_lat[15];
        neg_fwd_r   <= in_fwd[15];
        neg_turn_r  <= in_turn[15];
      end
      OP_MUL_LAT: begin
        prod_r <= prod_nxt;
      end
      OP_MUL_TURN: begin
        lat_m_r <= prod_r[30:15];
        prod_r  <= prod_nxt;
      end
      OP_MUL_FWD: begin
        turn_m_r <= prod_r[30:15];
        prod_r   <= prod_nxt;
      end
      OP_MUL_SPR: begin
        prod_r <= prod_nxt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hold_r  <= '0;
      lat_hold_r  <= '0;
      turn_hold_r <= '0;
    end else if (cmd.op == OP_COMMIT) begin
      fwd_hold_r  <= fwd_sat;
      lat_hold_r  <= lat_sat;
      turn_hold_r <= turn_sat;
    end
  end

  assign fwd_hold  = fwd_hold_r;
  assign lat_hold  = lat_hold_r;
  assign turn_hold = turn_hold_r;

endmodule

`default_nettype wire

@@ hw/rtl/jls_ctrl.sv @@
// ----------------------------------------------------------------------------
// jls_ctrl: sequencer controller
// Steps the datapath through one item and keeps the locomotion phase,
// button history, sprint state and the stand-up millisecond counter.
// ----------------------------------------------------------------------------
`default_nettype none

module jls_ctrl import jls_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_t    cfg,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic    in_mode,
  input  wire logic    in_confirm,
  input  wire logic    in_sprint,
  input  wire logic    out_free,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts,
  output res_t         res
);

  ctl_state_t state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic       sprinting_r, sprinting_nxt;
  logic       sprint_prev_r, sprint_prev_nxt;
  logic       confirm_prev_r, confirm_prev_nxt;
  logic       confirm_r, confirm_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  phase_t     res_phase_r, res_phase_nxt;
  logic       res_valid_r, res_valid_nxt;
  logic       res_stand_r, res_stand_nxt;
  logic       res_start_r, res_start_nxt;
  logic       res_stop_r, res_stop_nxt;
  speed_cmd_t res_speed_r, res_speed_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= CS_IDLE;
      phase_r        <= PH_IDLE;
      sprinting_r    <= 1'b0;
      sprint_prev_r  <= 1'b0;
      confirm_prev_r <= 1'b0;
      confirm_r      <= 1'b0;
      elapsed_r      <= '0;
      res_phase_r    <= PH_IDLE;
      res_valid_r    <= 1'b0;
      res_stand_r    <= 1'b0;
      res_start_r    <= 1'b0;
      res_stop_r     <= 1'b0;
      res_speed_r    <= SPD_NONE;
    end else begin
      state_r        <= state_nxt;
      phase_r        <= phase_nxt;
      sprinting_r    <= sprinting_nxt;
      sprint_prev_r  <= sprint_prev_nxt;
      confirm_prev_r <= confirm_prev_nxt;
      confirm_r      <= confirm_nxt;
      elapsed_r      <= elapsed_nxt;
      res_phase_r    <= res_phase_nxt;
      res_valid_r    <= res_valid_nxt;
      res_stand_r    <= res_stand_nxt;
      res_start_r    <= res_start_nxt;
      res_stop_r     <= res_stop_nxt;
      res_speed_r    <= res_speed_nxt;
    end
  end

  always_comb begin
    phase_t ph;
    state_nxt        = state_r;
    phase_nxt        = phase_r;
    sprinting_nxt    = sprinting_r;
    sprint_prev_nxt  = sprint_prev_r;
    confirm_prev_nxt = confirm_prev_r;
    confirm_nxt      = confirm_r;
    elapsed_nxt      = elapsed_r;
    res_phase_nxt    = res_phase_r;
    res_valid_nxt    = res_valid_r;
    res_stand_nxt    = res_stand_r;
    res_start_nxt    = res_start_r;
    res_stop_nxt     = res_stop_r;
    res_speed_nxt    = res_speed_r;
    ph               = phase_r;
    cmd.op           = OP_NONE;
    cmd.sprint       = sprinting_r;
    res.emit         = 1'b0;
    res.phase        = res_phase_r;
    res.vel_valid    = res_valid_r;
    res.stand        = res_stand_r;
    res.start        = res_start_r;
    res.speed        = res_speed_r;
    res.stop         = res_stop_r;
    in_ready         = (state_r == CS_IDLE);

    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          res_phase_nxt = phase_r;
          res_valid_nxt = 1'b0;
          res_stand_nxt = 1'b0;
          res_start_nxt = 1'b0;
          res_stop_nxt  = 1'b0;
          res_speed_nxt = SPD_NONE;
          state_nxt     = CS_EMIT;
          if (in_mode) begin
            if (phase_r == PH_STANDING && elapsed_r != ELAPSED_MAX) begin
              elapsed_nxt = elapsed_r + 16'd1;
            end
          end else if (phase_r == PH_STOPPED) begin
            // Terminal phase: nothing changes.
          end else if (phase_r == PH_ACTIVE && in_confirm && !confirm_prev_r) begin
            confirm_prev_nxt = 1'b1;
            phase_nxt        = PH_STOPPED;
            res_phase_nxt    = PH_STOPPED;
            res_stop_nxt     = 1'b1;
            res_valid_nxt    = 1'b1;
          end else begin
            if (in_sprint && !sprint_prev_r) begin
              sprinting_nxt = 1'b1;
              res_speed_nxt = SPD_HIGH;
            end else if (!in_sprint && sprint_prev_r) begin
              sprinting_nxt = 1'b0;
              res_speed_nxt = SPD_NORMAL;
            end
            sprint_prev_nxt = in_sprint;
            confirm_nxt     = in_confirm;
            cmd.op          = OP_LOAD;
            state_nxt       = CS_LAT;
          end
        end
      end
      CS_LAT: begin
        cmd.op    = OP_MUL_LAT;
        state_nxt = CS_TURN;
      end
      CS_TURN: begin
        cmd.op    = OP_MUL_TURN;
        state_nxt = CS_FWD;
      end
      CS_FWD: begin
        cmd.op    = OP_MUL_FWD;
        state_nxt = sprinting_r ? CS_SPR : CS_FIN;
      end
      CS_SPR: begin
        cmd.op    = OP_MUL_SPR;
        state_nxt = CS_FIN;
      end
      CS_FIN: begin
        cmd.op = OP_COMMIT;
        unique case (phase_r)
          PH_IDLE: begin
            if (sts.moved) begin
              ph            = PH_STANDING;
              res_stand_nxt = 1'b1;
              elapsed_nxt   = '0;
            end
          end
          PH_STANDING: begin
            if (elapsed_r > cfg.standup_wait_ms) begin
              ph = PH_AWAIT;
            end
          end
          PH_AWAIT: begin
            if (confirm_r && !confirm_prev_r) begin
              ph            = PH_ACTIVE;
              res_start_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
        phase_nxt        = ph;
        res_phase_nxt    = ph;
        res_valid_nxt    = (ph == PH_ACTIVE);
        confirm_prev_nxt = confirm_r;
        state_nxt        = CS_EMIT;
      end
      CS_EMIT: begin
        res.emit = out_free;
        if (out_free) begin
          state_nxt = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/joystick_locomotion_sequencer.sv @@
// ----------------------------------------------------------------------------
// joystick_locomotion_sequencer: stick shaping and startup sequencing
// Turns controller samples and millisecond ticks into velocity commands and
// stand-up, start, speed-mode and stop command pulses.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Contents
//  in_      slave      in_tvalid/in_tready    sample or tick, one per transfer
//  out_     master     out_tvalid/out_tready  one result per input transfer
//  cfg_     slave      cfg_valid/cfg_ready    register index and write data
//
// A tick, a sample in the stopped phase and the stop press go from acceptance
// straight to the emit state, which loads the output register. Other samples
// pass the lateral, turn, forward, sprint (while sprinting) and commit states:
// the single shared 16x16 multiplier is used once per axis and once more for
// the sprint gain. A new item is accepted once the controller is back in its
// idle state, even while the previous result still waits in the output
// register; the controller stalls only when it must load a result and the
// register is still full. Reset is synchronous and active low; it restores
// the configuration defaults and the idle phase. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_locomotion_sequencer import jls_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [15:0] lateral_axis, [31:16] forward_axis, [47:32] turn_axis,
  // [48] confirm_button, [49] sprint_button, [55:50] zero
  input  wire logic [55:0] in_tdata,
  // [0] mode: 0 controller sample, 1 millisecond tick
  input  wire logic        in_tuser,
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] phase, [18:3] forward_velocity, [34:19] lateral_velocity,
  // [50:35] turn_velocity, [51] velocity_valid, [52] stand_up_pulse,
  // [53] start_pulse, [55:54] speed_mode_cmd, [56] stop_pulse, [63:57] zero
  output logic [63:0]      out_tdata,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t    cfg_r;
  dp_cmd_t cmd;
  dp_sts_t sts;
  res_t    res;
  logic    out_valid_r;
  logic [63:0] out_data_r;
  logic    out_free;
  logic signed [15:0] fwd_hold, lat_hold, turn_hold;
  logic signed [15:0] fwd_out, lat_out, turn_out;

  // Configuration registers. The user must write only while no item is in flight; the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone         <= DEADZONE_RST;
      cfg_r.forward_gain     <= FORWARD_GAIN_RST;
      cfg_r.lateral_gain     <= LATERAL_GAIN_RST;
      cfg_r.turn_gain        <= TURN_GAIN_RST;
      cfg_r.sprint_gain      <= SPRINT_GAIN_RST;
      cfg_r.standup_wait_ms  <= STANDUP_WAIT_RST;
      cfg_r.motion_threshold <= MOTION_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_DEADZONE:     cfg_r.deadzone         <= cfg_data[14:0];
        REG_FORWARD_GAIN: cfg_r.forward_gain     <= cfg_data;
        REG_LATERAL_GAIN: cfg_r.lateral_gain     <= cfg_data;
        REG_TURN_GAIN:    cfg_r.turn_gain        <= cfg_data;
        REG_SPRINT_GAIN:  cfg_r.sprint_gain      <= cfg_data;
        REG_STANDUP_WAIT: cfg_r.standup_wait_ms  <= cfg_data;
        REG_MOTION_THR:   cfg_r.motion_threshold <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid_r || out_tready;

  jls_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_mode    (in_tuser),
    .in_confirm (in_tdata[48]),
    .in_sprint  (in_tdata[49]),
    .out_free   (out_free),
    .cmd        (cmd),
    .sts        (sts),
    .res        (res)
  );

  jls_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_lat    ($signed(in_tdata[15:0])),
    .in_fwd    ($signed(in_tdata[31:16])),
    .in_turn   ($signed(in_tdata[47:32])),
    .cmd       (cmd),
    .sts       (sts),
    .fwd_hold  (fwd_hold),
    .lat_hold  (lat_hold),
    .turn_hold (turn_hold)
  );

  // Velocities are only reported when a velocity command goes out.
  assign fwd_out  = res.vel_valid ? fwd_hold  : 16'sd0;
  assign lat_out  = res.vel_valid ? lat_hold  : 16'sd0;
  assign turn_out = res.vel_valid ? turn_hold : 16'sd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.emit) begin
      out_data_r <= {7'd0, res.stop, res.speed, res.start, res.stand, res.vel_valid,
                     turn_out, lat_out, fwd_out, res.phase};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A result is never loaded over one that has not been transferred.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.emit |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending output transfer");

  // One item at a time: the cycle after a transfer in, no further input is taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in flight");

  // A stop command always reports the stopped phase.
  a_stop_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (res.emit && res.stop) |-> (res.phase == PH_STOPPED))
    else $error("stop pulse without stopped phase");

  // A stand-up command is only issued on entry to the standing phase.
  a_stand_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (res.emit && res.stand) |-> (res.phase == PH_STANDING && !res.vel_valid))
    else $error("stand-up pulse outside the standing phase");

endmodule

`default_nettype wire
